### hw/rtl/dfsmc_pkg.sv
// Shared types, codes, microcode ROM and helper functions for the maze carver.
// Depends on nothing; imported by dfs_maze_carver_core and tb_dfs_maze_carver_core.
package dfsmc_pkg;

    // Default size limits of the room grid
    localparam int DEF_MAX_ROOMS_ACROSS = 32;
    localparam int DEF_MAX_ROOMS_DOWN   = 32;

    // Register fields and configuration map
    localparam int SIZE_W     = 6;
    localparam int COORD_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ROOMS_ACROSS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROOMS_DOWN   = 1'b1;
    localparam logic [SIZE_W-1:0]    SIZE_RESET       = 6'd5;

    // Item actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_CARVE = 1'b1;

    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [COORD_W-1:0] coord_t;

    // Input item
    typedef struct packed {
        logic        action;
        logic [15:0] random_value;
    } item_t;

    // Result item
    typedef struct packed {
        logic   carved;
        coord_t wall_row;
        coord_t wall_col;
        coord_t room_row;
        coord_t room_col;
        logic   done_res;
    } result_t;

    // Directions in search order
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    // Sequencer jump conditions
    typedef enum logic [2:0] {
        C_NEXT   = 3'd0,  // fall through
        C_JUMP   = 3'd1,  // always take target
        C_ACCEPT = 3'd2,  // wait for item; start -> target, carve -> next
        C_EMPTY  = 3'd3,  // stack empty -> target
        C_NOFREE = 3'd4,  // no free neighbour -> target
        C_SWEEP  = 3'd5,  // hold until sweep reaches last entry
        C_BOOT   = 3'd6,  // after reset clear -> target
        C_OUT    = 3'd7   // hold until output register free, then target
    } cond_t;

    typedef logic [3:0] step_t;

    // Microprogram addresses
    localparam step_t S_IDLE   = 4'd0;
    localparam step_t S_POP    = 4'd1;
    localparam step_t S_LOAD   = 4'd2;
    localparam step_t S_PR_R   = 4'd3;
    localparam step_t S_PR_D   = 4'd4;
    localparam step_t S_PR_L   = 4'd5;
    localparam step_t S_DECIDE = 4'd6;
    localparam step_t S_PICK   = 4'd7;
    localparam step_t S_MARK   = 4'd8;
    localparam step_t S_CLR    = 4'd9;
    localparam step_t S_SEED   = 4'd10;
    localparam step_t S_FINISH = 4'd11;

    // One control word
    typedef struct packed {
        cond_t cond;
        step_t target;
        logic  pop;       // pop one stack entry, or flag done when empty
        logic  load_cur;  // take popped room as current
        logic  vis_rd;    // read visited bit of a neighbour
        dir_t  vis_dir;
        logic  cap;       // capture previous neighbour read
        logic  decide;    // latch free set and its count
        logic  pick;      // choose direction, push current back
        logic  mark;      // mark and push new room, build result
        logic  sweep;     // clear one visited entry
        logic  seed;      // mark and push the first room
        logic  finish;    // hand result to the output register
    } uword_t;

    // Microcode ROM
    function automatic uword_t ucode(step_t pc);
        uword_t w;
        w        = '0;
        w.cond   = C_NEXT;
        w.target = S_IDLE;
        w.vis_dir = DIR_UP;
        unique case (pc)
            S_IDLE:   begin w.cond = C_ACCEPT; w.target = S_CLR; end
            S_POP:    begin w.pop = 1'b1; w.cond = C_EMPTY; w.target = S_FINISH; end
            S_LOAD:   begin w.load_cur = 1'b1; w.vis_rd = 1'b1; w.vis_dir = DIR_UP; end
            S_PR_R:   begin w.vis_rd = 1'b1; w.vis_dir = DIR_RIGHT; w.cap = 1'b1; end
            S_PR_D:   begin w.vis_rd = 1'b1; w.vis_dir = DIR_DOWN; w.cap = 1'b1; end
            S_PR_L:   begin w.vis_rd = 1'b1; w.vis_dir = DIR_LEFT; w.cap = 1'b1; end
            S_DECIDE:
            begin
                w.cap    = 1'b1;
                w.decide = 1'b1;
                w.cond   = C_NOFREE;
                w.target = S_POP;
            end
            S_PICK:   begin w.pick = 1'b1; end
            S_MARK:   begin w.mark = 1'b1; w.cond = C_JUMP; w.target = S_FINISH; end
            S_CLR:    begin w.sweep = 1'b1; w.cond = C_SWEEP; end
            S_SEED:   begin w.seed = 1'b1; w.cond = C_BOOT; w.target = S_IDLE; end
            S_FINISH: begin w.finish = 1'b1; w.cond = C_OUT; w.target = S_IDLE; end
            default:  begin w.cond = C_JUMP; w.target = S_IDLE; end
        endcase
        return w;
    endfunction

    // Neighbour in direction d lies inside the current size
    function automatic logic nbr_inside(coord_t r, coord_t c, dir_t d,
                                        size_t rows, size_t cols);
        coord_t rows7;
        coord_t cols7;
        logic   ok;
        rows7 = COORD_W'(rows);
        cols7 = COORD_W'(cols);
        unique case (d)
            DIR_UP:    ok = (r != '0) && ((r - 7'd1) < rows7) && (c < cols7);
            DIR_RIGHT: ok = (r < rows7) && ((c + 7'd1) < cols7);
            DIR_DOWN:  ok = ((r + 7'd1) < rows7) && (c < cols7);
            DIR_LEFT:  ok = (c != '0) && (r < rows7) && ((c - 7'd1) < cols7);
            default:   ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Number of free directions
    function automatic logic [2:0] count_free(logic [3:0] f);
        return {2'b00, f[0]} + {2'b00, f[1]} + {2'b00, f[2]} + {2'b00, f[3]};
    endfunction

    // Entry 'pick' of the free directions, in search order
    function automatic dir_t select_dir(logic [3:0] f, logic [1:0] pick);
        logic [1:0] left;
        dir_t       sel;
        logic       found;
        left  = pick;
        sel   = DIR_UP;
        found = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (f[i] && !found) begin
                if (left == 2'd0) begin
                    sel   = dir_t'(2'(i));
                    found = 1'b1;
                end
                else begin
                    left = left - 2'd1;
                end
            end
        end
        return sel;
    endfunction

endpackage

### hw/rtl/dfs_maze_carver_core.sv
// Microcoded depth-first maze carver: sequencer, visited map, path stack.
// Depends on dfsmc_pkg (types, microcode ROM, direction helpers).
//
// Usage:
//   item channel (item_valid/item_stall/item) takes one command: action 0
//   starts a new maze, action 1 carves one step using item.random_value.
//   result channel (result_valid/result_stall/result) returns exactly one
//   result per command: the opened wall and new room, start marker, or done.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes rooms_across
//   (index 0) and rooms_down (index 1); always ready, write only when idle.
// Steps (one item in flight; item_stall is high while it is worked on):
//   carve: pop, load, probes, decide, pick, mark, finish; every extra entry
//     popped while backtracking repeats pop to decide (one visited-map read
//     port, four neighbour reads per room); empty stack: pop, finish (done).
//   start: sweep over all 2^(clog2(MAX_ROOMS_DOWN) + clog2(MAX_ROOMS_ACROSS))
//     visited-map entries (1024 by default), then seed and finish.
// Reset: the same clearing sweep runs once after reset; item_stall stays high
//   until it completes. Stack is empty and sizes return to 5 x 5.
// Receiver stall: the result waits in the output register; the next item may
//   be accepted and worked on, holding in its final step until the slot frees.
module dfs_maze_carver_core
    import dfsmc_pkg::*;
#(
    parameter int MAX_ROOMS_ACROSS = DEF_MAX_ROOMS_ACROSS,
    parameter int MAX_ROOMS_DOWN   = DEF_MAX_ROOMS_DOWN
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command items
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    // results
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  size_t                cfg_data
);

    localparam int RW         = $clog2(MAX_ROOMS_DOWN);
    localparam int CW         = $clog2(MAX_ROOMS_ACROSS);
    localparam int VIS_AW     = RW + CW;
    localparam int VIS_DEPTH  = 1 << VIS_AW;
    localparam int ROOM_COUNT = MAX_ROOMS_ACROSS * MAX_ROOMS_DOWN;
    localparam int SAW        = $clog2(ROOM_COUNT);
    localparam int SDW        = $clog2(ROOM_COUNT + 1);

    typedef logic [VIS_AW-1:0] room_t;

    // Size register with clamp to 1..max
    function automatic size_t clamp_size(size_t v, int maxv);
        size_t r;
        if (v == '0)
            r = size_t'(1);
        else if (COORD_W'(v) > COORD_W'(maxv))
            r = size_t'(maxv);
        else
            r = v;
        return r;
    endfunction

    // Room address of a neighbour (wraps freely; range is checked apart)
    function automatic room_t nbr_addr(room_t base, dir_t d);
        logic [RW-1:0] r;
        logic [CW-1:0] c;
        r = base[VIS_AW-1:CW];
        c = base[CW-1:0];
        unique case (d)
            DIR_UP:    r = r - 1'b1;
            DIR_RIGHT: c = c + 1'b1;
            DIR_DOWN:  r = r + 1'b1;
            DIR_LEFT:  c = c - 1'b1;
            default:   r = r;
        endcase
        return {r, c};
    endfunction

    // Control state
    step_t           pc_reg, pc_next;
    logic            boot_reg, boot_next;
    logic [SDW-1:0]  depth_reg, depth_next;
    room_t           sweep_reg, sweep_next;
    logic            result_valid_reg, result_valid_next;
    size_t           rooms_across_reg, rooms_down_reg;

    // Payload registers
    logic [15:0]     rv_reg;
    room_t           cur_reg;
    room_t           stack_rd_reg;
    logic            vis_rd_reg;
    dir_t            rd_dir_reg;
    logic [3:0]      free_reg, free_next;
    logic [2:0]      count_reg;
    dir_t            sel_reg;
    result_t         res_reg, res_next;
    result_t         result_reg;

    // Memories
    logic            visited_mem [VIS_DEPTH];
    room_t           stack_mem   [ROOM_COUNT];

    uword_t          uc;
    logic            accept;
    logic            out_free;
    logic            stack_empty;
    logic            can_push;
    logic            free_in;
    logic [2:0]      count_now;
    logic [18:0]     pick_prod;
    coord_t          cur_r7, cur_c7, new_r7, new_c7;
    room_t           new_room;
    room_t           vis_rd_addr;
    logic            vis_we, vis_wdata;
    room_t           vis_waddr;
    logic            stk_we;
    logic [SAW-1:0]  stk_waddr;
    room_t           stk_wdata;

    assign uc          = ucode(pc_reg);
    assign item_stall  = (pc_reg != S_IDLE);
    assign accept      = item_valid && !item_stall;
    assign out_free    = !result_valid_reg || !result_stall;
    assign stack_empty = (depth_reg == '0);
    assign can_push    = (depth_reg < SDW'(ROOM_COUNT));
    assign cfg_ready   = 1'b1;
    assign result_valid = result_valid_reg;
    assign result      = result_reg;

    // Current room and its chosen neighbour in grid terms
    assign cur_r7 = COORD_W'(cur_reg[VIS_AW-1:CW]);
    assign cur_c7 = COORD_W'(cur_reg[CW-1:0]);
    assign new_r7 = (sel_reg == DIR_UP)   ? cur_r7 - 7'd1 :
                    (sel_reg == DIR_DOWN) ? cur_r7 + 7'd1 : cur_r7;
    assign new_c7 = (sel_reg == DIR_LEFT)  ? cur_c7 - 7'd1 :
                    (sel_reg == DIR_RIGHT) ? cur_c7 + 7'd1 : cur_c7;
    assign new_room = {new_r7[RW-1:0], new_c7[CW-1:0]};

    // Neighbour probe result and direction choice
    assign free_in   = nbr_inside(cur_r7, cur_c7, rd_dir_reg, rooms_down_reg,
                                  rooms_across_reg) && !vis_rd_reg;
    assign free_next = {free_in, free_reg[3:1]};
    assign count_now = count_free(free_next);
    assign pick_prod = 19'(rv_reg) * 19'(count_reg);
    assign vis_rd_addr = nbr_addr(uc.load_cur ? stack_rd_reg : cur_reg, uc.vis_dir);

    // Sequencer: next step
    always_comb
    begin
        pc_next = pc_reg;
        unique case (uc.cond)
            C_NEXT:   pc_next = pc_reg + 4'd1;
            C_JUMP:   pc_next = uc.target;
            C_ACCEPT:
            begin
                if (accept)
                    pc_next = (item.action == ACT_START) ? uc.target : pc_reg + 4'd1;
            end
            C_EMPTY:  pc_next = stack_empty ? uc.target : pc_reg + 4'd1;
            C_NOFREE: pc_next = (count_now == 3'd0) ? uc.target : pc_reg + 4'd1;
            C_SWEEP:  pc_next = (&sweep_reg) ? pc_reg + 4'd1 : pc_reg;
            C_BOOT:   pc_next = boot_reg ? uc.target : pc_reg + 4'd1;
            C_OUT:    pc_next = out_free ? uc.target : pc_reg;
            default:  pc_next = S_IDLE;
        endcase
    end

    // Datapath control from the current control word
    always_comb
    begin
        boot_next         = boot_reg;
        depth_next        = depth_reg;
        sweep_next        = sweep_reg;
        result_valid_next = result_valid_reg;
        res_next          = res_reg;
        vis_we            = 1'b0;
        vis_waddr         = sweep_reg;
        vis_wdata         = 1'b0;
        stk_we            = 1'b0;
        stk_waddr         = depth_reg[SAW-1:0];
        stk_wdata         = cur_reg;

        // output register drains
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
        if (uc.finish && out_free)
            result_valid_next = 1'b1;

        // clearing sweep
        if (uc.sweep)
        begin
            vis_we     = 1'b1;
            vis_waddr  = sweep_reg;
            vis_wdata  = 1'b0;
            sweep_next = sweep_reg + 1'b1;
        end

        // first room of a new maze
        if (uc.seed)
        begin
            boot_next = 1'b0;
            if (!boot_reg)
            begin
                vis_we     = 1'b1;
                vis_waddr  = '0;
                vis_wdata  = 1'b1;
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = '0;
                depth_next = SDW'(1);
                res_next   = '0;
                res_next.room_row = 7'd1;
                res_next.room_col = 7'd1;
            end
        end

        // pop, or report done
        if (uc.pop)
        begin
            if (stack_empty)
            begin
                res_next          = '0;
                res_next.done_res = 1'b1;
            end
            else
            begin
                depth_next = depth_reg - 1'b1;
            end
        end

        // push current room back
        if (uc.pick && can_push)
        begin
            stk_we     = 1'b1;
            stk_waddr  = depth_reg[SAW-1:0];
            stk_wdata  = cur_reg;
            depth_next = depth_reg + 1'b1;
        end

        // mark and push the new room, build the result
        if (uc.mark)
        begin
            vis_we    = 1'b1;
            vis_waddr = new_room;
            vis_wdata = 1'b1;
            if (can_push)
            begin
                stk_we     = 1'b1;
                stk_waddr  = depth_reg[SAW-1:0];
                stk_wdata  = new_room;
                depth_next = depth_reg + 1'b1;
            end
            res_next          = '0;
            res_next.carved   = 1'b1;
            res_next.room_row = (new_r7 << 1) + 7'd1;
            res_next.room_col = (new_c7 << 1) + 7'd1;
            res_next.wall_row = (sel_reg == DIR_UP)   ? (cur_r7 << 1) :
                                (sel_reg == DIR_DOWN) ? (cur_r7 << 1) + 7'd2 :
                                                        (cur_r7 << 1) + 7'd1;
            res_next.wall_col = (sel_reg == DIR_LEFT)  ? (cur_c7 << 1) :
                                (sel_reg == DIR_RIGHT) ? (cur_c7 << 1) + 7'd2 :
                                                         (cur_c7 << 1) + 7'd1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= S_CLR;
            boot_reg         <= 1'b1;
            depth_reg        <= '0;
            sweep_reg        <= '0;
            result_valid_reg <= 1'b0;
            rooms_across_reg <= SIZE_RESET;
            rooms_down_reg   <= SIZE_RESET;
        end
        else
        begin
            pc_reg           <= pc_next;
            boot_reg         <= boot_next;
            depth_reg        <= depth_next;
            sweep_reg        <= sweep_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ROOMS_ACROSS: rooms_across_reg <= clamp_size(cfg_data, MAX_ROOMS_ACROSS);
                    REG_ROOMS_DOWN:   rooms_down_reg   <= clamp_size(cfg_data, MAX_ROOMS_DOWN);
                    default:          rooms_down_reg   <= rooms_down_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            rv_reg <= item.random_value;
        if (uc.load_cur)
            cur_reg <= stack_rd_reg;
        if (uc.cap)
            free_reg <= free_next;
        if (uc.decide)
            count_reg <= count_now;
        if (uc.pick)
            sel_reg <= select_dir(free_reg, pick_prod[17:16]);
        res_reg <= res_next;
        if (uc.finish && out_free)
            result_reg <= res_reg;
    end

    // Visited map: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (vis_we)
            visited_mem[vis_waddr] <= vis_wdata;
        if (uc.vis_rd)
        begin
            vis_rd_reg <= visited_mem[vis_rd_addr];
            rd_dir_reg <= uc.vis_dir;
        end
    end

    // Path stack: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
        if (uc.pop && !stack_empty)
            stack_rd_reg <= stack_mem[SAW'(depth_reg - 1'b1)];
    end

endmodule

### dv/tb_dfs_maze_carver_core.sv
// Self-checking testbench for dfs_maze_carver_core: directed and random maze commands
// are checked against a behavioural depth-first carver kept in step with the block.
// Depends on dfsmc_pkg and dfs_maze_carver_core only.
module tb_dfs_maze_carver_core;
    import dfsmc_pkg::*;

    localparam int ACROSS_MAX     = DEF_MAX_ROOMS_ACROSS;
    localparam int DOWN_MAX       = DEF_MAX_ROOMS_DOWN;
    localparam int ROOM_SLOTS     = ACROSS_MAX * DOWN_MAX;
    localparam int TARGET_ITEMS   = 2000;
    localparam int IDLE_PCT       = 36;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int TAIL_CYCLES    = 40;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    item_t                item         = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = REG_ROOMS_ACROSS;
    size_t                cfg_data     = '0;

    // Command queue feeding the driver, carve outcomes awaiting the block
    item_t   carve_cmds[$];
    result_t carve_outcomes[$];
    int      cmds_outstanding = 0;
    int      items_queued     = 0;
    int      mismatches       = 0;
    int      stuck_cycles     = 0;
    bit      steady           = 1'b0;

    // Shadow copy of the carver state
    bit visited_rooms[ROOM_SLOTS];
    int trail[ROOM_SLOTS];
    int trail_depth = 0;
    int rooms_wide  = int'(SIZE_RESET);
    int rooms_tall  = int'(SIZE_RESET);

    dfs_maze_carver_core u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int clamp_rooms(size_t v, int maxv);
        if (int'(v) < 1)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic int row_step(dir_t d);
        case (d)
            DIR_UP:   return -1;
            DIR_DOWN: return 1;
            default:  return 0;
        endcase
    endfunction

    function automatic int col_step(dir_t d);
        case (d)
            DIR_LEFT:  return -1;
            DIR_RIGHT: return 1;
            default:   return 0;
        endcase
    endfunction

    // Room inside the current size and not yet visited
    function automatic bit room_open(int nr, int nc);
        if (nr < 0 || nc < 0 || nr >= rooms_tall || nc >= rooms_wide)
            return 1'b0;
        return !visited_rooms[nr * ACROSS_MAX + nc];
    endfunction

    // Full stack drops the push
    function automatic void push_trail(int idx);
        if (trail_depth < ROOM_SLOTS)
        begin
            trail[trail_depth] = idx;
            trail_depth++;
        end
    endfunction

    // One command through the shadow carver; returns the outcome it gives
    function automatic result_t predict_carve(item_t cmd);
        result_t  res;
        int       idx, r, c, nr, nc, cnt, pick;
        dir_t     dir, sel;
        bit [3:0] open_dirs;
        res = '0;
        if (cmd.action == ACT_START)
        begin
            foreach (visited_rooms[i])
                visited_rooms[i] = 1'b0;
            trail_depth      = 0;
            visited_rooms[0] = 1'b1;
            push_trail(0);
            res.room_row = coord_t'(1);
            res.room_col = coord_t'(1);
            return res;
        end
        // backtrack until a room with a free neighbour turns up
        while (trail_depth > 0)
        begin
            trail_depth--;
            idx = trail[trail_depth];
            r   = idx / ACROSS_MAX;
            c   = idx % ACROSS_MAX;
            cnt = 0;
            for (int i = 0; i < 4; i++)
            begin
                dir          = dir_t'(2'(i));
                open_dirs[i] = room_open(r + row_step(dir), c + col_step(dir));
                cnt += int'(open_dirs[i]);
            end
            if (cnt == 0)
                continue;
            push_trail(idx);
            pick = (int'(cmd.random_value) * cnt) >> 16;
            sel  = DIR_UP;
            for (int i = 0; i < 4; i++)
            begin
                if (open_dirs[i])
                begin
                    if (pick == 0)
                        sel = dir_t'(2'(i));
                    pick--;
                end
            end
            nr = r + row_step(sel);
            nc = c + col_step(sel);
            visited_rooms[nr * ACROSS_MAX + nc] = 1'b1;
            push_trail(nr * ACROSS_MAX + nc);
            res.carved   = 1'b1;
            res.wall_row = coord_t'(2 * r + 1 + row_step(sel));
            res.wall_col = coord_t'(2 * c + 1 + col_step(sel));
            res.room_row = coord_t'(2 * nr + 1);
            res.room_col = coord_t'(2 * nc + 1);
            return res;
        end
        res.done_res = 1'b1;
        return res;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_item(logic action, logic [15:0] word);
        item_t cmd;
        cmd.action       = action;
        cmd.random_value = word;
        carve_cmds.insert(carve_cmds.size(), cmd);
        cmds_outstanding++;
        items_queued++;
    endtask

    // Hold off until every command has been taken and answered
    task automatic wait_drained();
        while (cmds_outstanding != 0 || carve_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Both size registers, back to back, valid held across the pair
    task automatic write_sizes(size_t across_val, size_t down_val);
        cfg_index <= REG_ROOMS_ACROSS;
        cfg_data  <= across_val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        rooms_wide = clamp_rooms(across_val, ACROSS_MAX);
        cfg_index <= REG_ROOMS_DOWN;
        cfg_data  <= down_val;
        do @(posedge clk); while (!cfg_ready);
        rooms_tall = clamp_rooms(down_val, DOWN_MAX);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly small grids, now and then the limits or out-of-range values
    function automatic size_t pick_size();
        case ($urandom_range(0, 19))
            0:       return size_t'(0);
            1:       return size_t'($urandom_range(33, 63));
            2:       return size_t'(32);
            default: return size_t'($urandom_range(1, 8));
        endcase
    endfunction

    // Driver: predicts on each accepted transaction, then offers the next command
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                carve_outcomes.insert(carve_outcomes.size(), predict_carve(item));
                cmds_outstanding--;
            end
            if (!item_valid || !item_stall)
            begin
                if (carve_cmds.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    item       <= carve_cmds.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction field by field, stalls at random
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (carve_outcomes.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result %h", result));
                end
                else
                begin
                    want = carve_outcomes.pop_front();
                    if (result.carved !== want.carved)
                        flag_mismatch($sformatf("carved got %0d want %0d",
                                                result.carved, want.carved));
                    if (result.wall_row !== want.wall_row)
                        flag_mismatch($sformatf("wall_row got %0d want %0d",
                                                result.wall_row, want.wall_row));
                    if (result.wall_col !== want.wall_col)
                        flag_mismatch($sformatf("wall_col got %0d want %0d",
                                                result.wall_col, want.wall_col));
                    if (result.room_row !== want.room_row)
                        flag_mismatch($sformatf("room_row got %0d want %0d",
                                                result.room_row, want.room_row));
                    if (result.room_col !== want.room_col)
                        flag_mismatch($sformatf("room_col got %0d want %0d",
                                                result.room_col, want.room_col));
                    if (result.done_res !== want.done_res)
                        flag_mismatch($sformatf("done_res got %0d want %0d",
                                                result.done_res, want.done_res));
                end
            end
            result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog: too long without any accepted transaction ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
            begin
                stuck_cycles <= 0;
            end
            else if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired at %0t", $time);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // Stimulus
    initial
    begin
        int phase;
        int n;
        int kind;
        phase = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // carve before any start, then a 5 x 5 maze at the default size
        queue_item(ACT_CARVE, 16'h1234);
        queue_item(ACT_START, 16'h0000);
        queue_item(ACT_CARVE, 16'h0000);
        queue_item(ACT_CARVE, 16'hFFFF);
        queue_item(ACT_CARVE, 16'h5555);
        queue_item(ACT_CARVE, 16'hAAAA);
        queue_item(ACT_CARVE, 16'h0001);
        queue_item(ACT_CARVE, 16'h8000);
        queue_item(ACT_START, 16'hFFFF);
        wait_drained();

        // zero clamps to a single room: done straight after the start
        write_sizes(size_t'(0), size_t'(0));
        queue_item(ACT_START, 16'h0000);
        queue_item(ACT_CARVE, 16'hFFFF);
        queue_item(ACT_CARVE, 16'h0000);
        wait_drained();

        // oversized width clamps to the maximum, a single row
        write_sizes(size_t'(63), size_t'(1));
        queue_item(ACT_START, 16'h0000);
        repeat (4) queue_item(ACT_CARVE, 16'hFFFF);
        wait_drained();

        // shrink mid-maze: stacked rooms now outside the grid get popped
        write_sizes(size_t'(1), size_t'(33));
        repeat (3) queue_item(ACT_CARVE, 16'h7FFF);
        wait_drained();

        // random phases, each ended by a full drain before the next size change
        while (items_queued < TARGET_ITEMS)
        begin
            phase++;
            steady = (phase >= 6 && phase < 12);
            write_sizes(pick_size(), pick_size());
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                // well-formed maze: one carve per remaining room up to 80, plus up to two extra
                n = rooms_wide * rooms_tall - 1;
                if (n > 80)
                    n = 80;
                n += $urandom_range(0, 2);
                queue_item(ACT_START, pick_word());
                repeat (n) queue_item(ACT_CARVE, pick_word());
            end
            else if (kind == 7)
            begin
                // carry on the old maze under the new size
                repeat ($urandom_range(3, 30)) queue_item(ACT_CARVE, pick_word());
            end
            else if (kind == 8)
            begin
                // noise
                repeat ($urandom_range(5, 20))
                    queue_item(($urandom_range(0, 7) == 0) ? ACT_START : ACT_CARVE,
                               pick_word());
            end
            else
            begin
                // restart halfway through
                queue_item(ACT_START, pick_word());
                repeat ((rooms_wide * rooms_tall) / 2 + 1) queue_item(ACT_CARVE, pick_word());
                queue_item(ACT_START, pick_word());
                repeat ($urandom_range(1, 6)) queue_item(ACT_CARVE, pick_word());
            end
            wait_drained();
        end

        steady = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
